### rtl/core/rpe_pkg.sv
`default_nettype none
package rpe_pkg;

  // Default table depth
  localparam int TableDepthDef = 32;

  // Word tags (top nibble)
  localparam logic [3:0] TagAzimuth = 4'h8;
  localparam logic [3:0] TagRange   = 4'h3;
  localparam logic [3:0] TagHeight  = 4'hC;

  // Azimuth acceptance limit below which a wrapped word is taken
  localparam logic [15:0] AzWrapLimit = 16'h8003;

  // Configuration register indexes
  localparam logic [2:0] CfgRangeTol  = 3'd0;
  localparam logic [2:0] CfgMaxAbs    = 3'd1;
  localparam logic [2:0] CfgTurnCnt   = 3'd2;
  localparam logic [2:0] CfgMinWidth  = 3'd3;
  localparam logic [2:0] CfgInhibit   = 3'd4;

  // Result kinds
  localparam logic KindHeader = 1'b0;
  localparam logic KindPlot   = 1'b1;

  // One target table entry
  typedef struct packed {
    logic [15:0] rng;
    logic [11:0] start_az;
    logic [7:0]  absences;
    logic [7:0]  height;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // One result item
  typedef struct packed {
    logic        kind;
    logic [3:0]  sector;
    logic [15:0] az;
    logic [15:0] rng;
    logic [7:0]  height;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/rpe_ram.sv
`default_nettype none
module rpe_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/radar_plot_extractor_core.sv
`default_nettype none
// Radar plot extractor. Tagged radar words (azimuth, range, height) come in on
// the in_ stream; sector headers and target plots leave on the out_ stream,
// with tlast marking the final result caused by one input word. The target
// table sits in a single-port-read RAM and is scanned one entry at a time,
// each entry read in one state and used in the next: a closed run is matched
// by a nearest-target search, and each accepted azimuth also ages and compacts
// the table, which holds at most TABLE_DEPTH targets. A new input word is
// taken only once the block is done with the last one, output stalls included.
// Table entries need no clearing after reset: only entries below the target
// count are read.
module radar_plot_extractor_core
  import rpe_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream: [15:0] word
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,
  // result stream: [3:0] sector, [19:4] plot_azimuth, [35:20] plot_range,
  // [43:36] plot_height, [47:44] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,
  // [0] kind
  output logic [0:0]       out_tuser,
  output logic             out_tlast,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [12:0] cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_SRD, ST_SCMP, ST_SEND, ST_ARD, ST_AUSE, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MD_HEIGHT, MD_CLOSE_AZ, MD_CLOSE_RNG
  } mode_t;

  state_t state_r;
  mode_t  mode_r;

  // configuration
  logic [11:0] range_tol_r;
  logic [7:0]  max_abs_r;
  logic [12:0] turn_cnt_r;
  logic [11:0] min_width_r;
  logic [11:0] inhibit_r;

  // block state
  logic [15:0] word_r;
  logic [15:0] last_az_r;
  logic        resync_r;
  logic        az_valid_r;
  logic        run_closed_r;
  logic [3:0]  cur_sector_r;
  logic [15:0] run_start_r;
  logic [11:0] run_az_r;
  logic        hpend_r;
  logic [7:0]  pend_height_r;
  logic [CW-1:0] count_r;

  // scan and ageing
  logic [15:0]   key_r;
  logic [CW-1:0] j_r;
  logic [CW-1:0] wr_r;
  logic [11:0]   best_r;
  logic          found_r;
  logic [AW-1:0] idx_r;
  entry_t        ent_r;

  // result holding register and output register
  logic    pend_v_r;
  result_t pend_r;
  logic    out_valid_r;
  result_t out_r;
  logic    out_last_r;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  rpe_ram #(.Width(EntryW), .Depth(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (j_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Decode of the held word
  logic [3:0]  tag;
  logic        az_accept;
  logic        rng_ok;
  logic        gap_close;
  logic [15:0] gap;

  always_comb begin
    tag       = word_r[15:12];
    az_accept = resync_r ||
                (({1'b0, word_r} < ({1'b0, last_az_r} + 17'd4)) &&
                 ((word_r > last_az_r) || (word_r < AzWrapLimit)));
    rng_ok    = word_r[11:0] >= inhibit_r;
    gap       = word_r - run_start_r;
    gap_close = gap > {4'b0, range_tol_r};
  end

  // Nearest-target distance
  logic [15:0] rng_diff;
  logic        closer;

  always_comb begin
    rng_diff = (key_r >= ram_rdata.rng) ? key_r - ram_rdata.rng : ram_rdata.rng - key_r;
    closer   = {4'b0, best_r} > rng_diff;
  end

  // Ageing and plot formation
  logic [7:0]  abs_inc;
  logic        expire;
  logic [13:0] fin14;
  logic [13:0] start14;
  logic [13:0] sum14;
  logic        wrap;
  logic [11:0] mid;
  logic [14:0] ext15;
  logic        wide;
  logic [3:0]  prev_sec;
  logic        emit_plot;
  logic        can_push;
  logic        stall;
  logic        push_out;

  always_comb begin
    abs_inc   = ram_rdata.absences + 8'd1;
    expire    = abs_inc >= max_abs_r;
    fin14     = {2'b0, run_az_r} - {6'b0, max_abs_r};
    start14   = {2'b0, ram_rdata.start_az};
    sum14     = start14 + fin14;
    wrap      = $signed(fin14) < $signed(start14);
    mid       = wrap ? (sum14[12:1] + turn_cnt_r[12:1]) : sum14[12:1];
    ext15     = {fin14[13], fin14} + (wrap ? 15'd4096 : 15'd0) - {1'b0, start14};
    wide      = $signed(ext15) >= $signed({3'b0, min_width_r});
    prev_sec  = (cur_sector_r == 4'd0) ? 4'd1 : cur_sector_r - 4'd1;
    emit_plot = expire && wide && ((mid[11:8] == cur_sector_r) || (mid[11:8] == prev_sec));
    can_push  = !out_valid_r || out_tready;
    stall     = emit_plot && pend_v_r && !can_push;
    push_out  = ((state_r == ST_AUSE) && !stall && emit_plot && pend_v_r) ||
                ((state_r == ST_FIN) && pend_v_r && can_push);
  end

  // RAM write selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ent_r;
    case (state_r)
      ST_SEND: begin
        if (mode_r == MD_HEIGHT) begin
          ram_we           = found_r;
          ram_wdata.height = pend_height_r;
        end else if (found_r) begin
          ram_we             = 1'b1;
          ram_wdata.absences = 8'd0;
        end else begin
          ram_we             = count_r < DepthC;
          ram_waddr          = count_r[AW-1:0];
          ram_wdata.rng      = run_start_r;
          ram_wdata.start_az = run_az_r;
          ram_wdata.absences = 8'd0;
          ram_wdata.height   = 8'd0;
        end
      end
      ST_AUSE: begin
        ram_we             = !stall && !expire;
        ram_waddr          = wr_r[AW-1:0];
        ram_wdata          = ram_rdata;
        ram_wdata.absences = abs_inc;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_r.height, out_r.rng, out_r.az, out_r.sector};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_tol_r <= 12'd8;
      max_abs_r   <= 8'd4;
      turn_cnt_r  <= 13'd4096;
      min_width_r <= 12'd2;
      inhibit_r   <= 12'd13;
    end else if (cfg_we) begin
      case (cfg_addr)
        CfgRangeTol: range_tol_r <= cfg_wdata[11:0];
        CfgMaxAbs:   max_abs_r   <= cfg_wdata[7:0];
        CfgTurnCnt:  turn_cnt_r  <= cfg_wdata;
        CfgMinWidth: min_width_r <= cfg_wdata[11:0];
        CfgInhibit:  inhibit_r   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= MD_HEIGHT;
      last_az_r     <= '0;
      resync_r      <= 1'b1;
      az_valid_r    <= 1'b0;
      run_closed_r  <= 1'b0;
      cur_sector_r  <= '0;
      run_start_r   <= '0;
      run_az_r      <= '0;
      hpend_r       <= 1'b0;
      pend_height_r <= '0;
      count_r       <= '0;
      j_r           <= '0;
      wr_r          <= '0;
      pend_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      // output register: load on a push, clear once taken
      if (push_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            word_r  <= in_tdata;
            state_r <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          j_r     <= '0;
          best_r  <= {1'b0, range_tol_r[11:1]} + 12'd1;
          found_r <= 1'b0;
          case (tag)
            TagAzimuth: begin
              hpend_r <= 1'b0;
              if (az_accept) begin
                resync_r   <= 1'b0;
                last_az_r  <= word_r;
                az_valid_r <= 1'b1;
                if (word_r[11:8] != cur_sector_r) begin
                  cur_sector_r <= word_r[11:8];
                  pend_v_r     <= 1'b1;
                  pend_r       <= '{kind: KindHeader, sector: word_r[11:8],
                                    az: 16'd0, rng: 16'd0, height: 8'd0};
                end
                if (!run_closed_r) begin
                  key_r   <= run_start_r;
                  mode_r  <= MD_CLOSE_AZ;
                  state_r <= ST_SRD;
                end else begin
                  run_az_r <= word_r[11:0];
                  wr_r     <= '0;
                  state_r  <= ST_ARD;
                end
                run_closed_r <= 1'b1;
              end else begin
                resync_r <= 1'b1;
                state_r  <= ST_FIN;
                if (word_r == last_az_r) begin
                  az_valid_r <= 1'b0;
                end else begin
                  count_r <= '0;
                end
              end
            end
            TagRange: begin
              if (rng_ok && hpend_r) begin
                hpend_r      <= 1'b0;
                run_closed_r <= 1'b1;
                key_r        <= word_r;
                mode_r       <= MD_HEIGHT;
                state_r      <= ST_SRD;
              end else if (rng_ok && az_valid_r && run_closed_r) begin
                run_start_r  <= word_r;
                run_closed_r <= 1'b0;
                state_r      <= ST_FIN;
              end else if (rng_ok && az_valid_r && gap_close) begin
                key_r   <= run_start_r;
                mode_r  <= MD_CLOSE_RNG;
                state_r <= ST_SRD;
              end else begin
                state_r <= ST_FIN;
              end
            end
            TagHeight: begin
              hpend_r       <= 1'b1;
              pend_height_r <= word_r[7:0];
              state_r       <= ST_FIN;
            end
            default: begin
              state_r <= ST_FIN;
            end
          endcase
        end

        // nearest-target search, read then compare
        ST_SRD: begin
          state_r <= (j_r < count_r) ? ST_SCMP : ST_SEND;
        end

        ST_SCMP: begin
          if (closer) begin
            best_r  <= rng_diff[11:0];
            found_r <= 1'b1;
            idx_r   <= j_r[AW-1:0];
            ent_r   <= ram_rdata;
          end
          j_r     <= j_r + 1'b1;
          state_r <= ST_SRD;
        end

        ST_SEND: begin
          if (mode_r != MD_HEIGHT && !found_r && count_r < DepthC) begin
            count_r <= count_r + 1'b1;
          end
          j_r  <= '0;
          wr_r <= '0;
          case (mode_r)
            MD_CLOSE_AZ: begin
              run_az_r <= word_r[11:0];
              state_r  <= ST_ARD;
            end
            MD_CLOSE_RNG: begin
              run_start_r <= word_r;
              state_r     <= ST_FIN;
            end
            default: begin
              state_r <= ST_FIN;
            end
          endcase
        end

        // ageing with in-place compaction
        ST_ARD: begin
          if (j_r < count_r) begin
            state_r <= ST_AUSE;
          end else begin
            count_r <= wr_r;
            state_r <= ST_FIN;
          end
        end

        ST_AUSE: begin
          if (!stall) begin
            if (emit_plot) begin
              if (pend_v_r) begin
                out_r      <= pend_r;
                out_last_r <= 1'b0;
              end
              pend_v_r <= 1'b1;
              pend_r   <= '{kind: KindPlot, sector: 4'd0, az: {4'h8, mid},
                            rng: ram_rdata.rng, height: ram_rdata.height};
            end
            if (!expire) begin
              wr_r <= wr_r + 1'b1;
            end
            j_r     <= j_r + 1'b1;
            state_r <= ST_ARD;
          end
        end

        // hand over the final result of this transaction
        ST_FIN: begin
          if (!pend_v_r) begin
            state_r <= ST_IDLE;
          end else if (can_push) begin
            out_r      <= pend_r;
            out_last_r <= 1'b1;
            pend_v_r   <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import rpe_pkg::*;

  typedef struct {
    logic        kind;
    logic [3:0]  sector;
    logic [15:0] az;
    logic [15:0] rng;
    logic [7:0]  height;
    logic        last;
  } plot_rec_t;

  localparam int Depth = 32;
  localparam int IdleLimit = 3000;
  localparam int SettleCycles = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = CfgRangeTol;
  logic [12:0] cfg_wdata = '0;

  radar_plot_extractor_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the extractor state
  logic [11:0] m_tol;
  logic [7:0]  m_max_abs;
  logic [12:0] m_turn;
  logic [11:0] m_min_w;
  logic [11:0] m_inhibit;
  logic [15:0] m_last_az;
  logic        m_resync, m_az_valid, m_run_closed, m_h_pending;
  logic [3:0]  m_sector;
  logic [15:0] m_run_rng;
  logic [11:0] m_run_az;
  logic [7:0]  m_pend_h;
  int          m_count;
  logic [15:0] t_rng [Depth];
  logic [11:0] t_az  [Depth];
  logic [7:0]  t_abs [Depth];
  logic [7:0]  t_h   [Depth];

  logic [15:0] word_q[$];
  plot_rec_t   plot_q[$];
  plot_rec_t   step_q[$];
  bit          failed = 1'b0;
  bit          hold_input = 1'b0;

  function automatic void emit_rec(logic kind, logic [3:0] sec, logic [15:0] az,
                                   logic [15:0] rng, logic [7:0] h);
    plot_rec_t r;
    r.kind = kind; r.sector = sec; r.az = az; r.rng = rng; r.height = h; r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  // nearest target within half the tolerance, first one wins on a tie
  function automatic bit nearest_target(logic [15:0] r, output int idx);
    int best, d;
    bit found;
    best = int'(m_tol >> 1) + 1;
    found = 1'b0;
    idx = 0;
    for (int j = 0; j < m_count; j++) begin
      d = (r >= t_rng[j]) ? int'(r) - int'(t_rng[j]) : int'(t_rng[j]) - int'(r);
      if (best > d) begin
        best = d;
        idx = j;
        found = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic void close_run();
    int idx;
    if (nearest_target(m_run_rng, idx)) t_abs[idx] = '0;
    else if (m_count < Depth) begin
      t_rng[m_count] = m_run_rng;
      t_az[m_count] = m_run_az;
      t_abs[m_count] = '0;
      t_h[m_count] = '0;
      m_count++;
    end
  endfunction

  function automatic void age_targets();
    int j, start, fin, sum;
    logic [31:0] usum;
    logic [11:0] mid;
    logic [3:0] prev;
    j = 0;
    while (j < m_count) begin
      t_abs[j] = t_abs[j] + 8'd1;
      if (t_abs[j] >= m_max_abs) begin
        start = int'(t_az[j]);
        fin = int'(m_run_az) - int'(m_max_abs);
        sum = start + fin;
        usum = sum;
        prev = (m_sector == 0) ? 4'd1 : m_sector - 4'd1;
        if (fin < start) begin
          mid = 12'((usum >> 1) + (m_turn >> 1));
          fin += 4096;
        end else mid = 12'(usum >> 1);
        if (fin - start >= int'(m_min_w))
          if (mid[11:8] == m_sector || mid[11:8] == prev)
            emit_rec(KindPlot, 4'd0, {4'h8, mid}, t_rng[j], t_h[j]);
        for (int i = j; i + 1 < m_count; i++) begin
          t_rng[i] = t_rng[i+1]; t_az[i] = t_az[i+1];
          t_abs[i] = t_abs[i+1]; t_h[i] = t_h[i+1];
        end
        m_count--;
      end else j++;
    end
  endfunction

  // Advance the shadow by one word and queue what the block must emit
  function automatic void track_word(logic [15:0] w);
    int idx;
    step_q.delete();
    if (w[15:12] == TagAzimuth) begin
      m_h_pending = 1'b0;
      if ((int'(w) < int'(m_last_az) + 4 && (w > m_last_az || w < AzWrapLimit))
          || m_resync) begin
        m_resync = 1'b0;
        m_last_az = w;
        m_az_valid = 1'b1;
        if (w[11:8] != m_sector) begin
          m_sector = w[11:8];
          emit_rec(KindHeader, w[11:8], '0, '0, '0);
        end
        if (!m_run_closed) close_run();
        m_run_closed = 1'b1;
        m_run_az = w[11:0];
        age_targets();
      end else begin
        m_resync = 1'b1;
        if (w == m_last_az) m_az_valid = 1'b0;
        else m_count = 0;
      end
    end else if (w[15:12] == TagRange) begin
      if (w[11:0] >= m_inhibit) begin
        if (m_h_pending) begin
          m_h_pending = 1'b0;
          m_run_closed = 1'b1;
          if (nearest_target(w, idx)) t_h[idx] = m_pend_h;
        end else if (m_az_valid) begin
          if (m_run_closed) begin
            m_run_rng = w;
            m_run_closed = 1'b0;
          end else if (16'(w - m_run_rng) > m_tol) begin
            close_run();
            m_run_rng = w;
          end
        end
      end
    end else if (w[15:12] == TagHeight) begin
      m_h_pending = 1'b1;
      m_pend_h = w[7:0];
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[k]) plot_q.push_back(step_q[k]);
  endfunction

  // Sender: bursts of random length, random gaps
  int burst_left = 0;
  int gap_left = 0;
  bit in_fire = 1'b0;

  always @(posedge clk) in_fire <= in_tvalid && in_tready;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_fire) begin
        // transaction still pending, hold
      end else if (gap_left > 0 || hold_input || word_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= word_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // Receiver stall pattern: always ready, random ready, or stall bursts, the mode re-picked at random
  int rx_cyc = 0;
  int rx_mode = 0;
  int rx_stall = 0;

  always @(negedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 64 == 0) rx_mode <= $urandom_range(0, 2);
    if (!rst_n) out_tready <= 1'b0;
    else if (rx_mode == 0) out_tready <= 1'b1;
    else if (rx_mode == 1) out_tready <= $urandom_range(0, 1);
    else if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      out_tready <= 1'b1;
      rx_stall <= $urandom_range(3, 20);
    end
  end

  // Input prediction and result checking
  int idle_cycles = 0;

  always @(posedge clk) begin
    plot_rec_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) track_word(in_tdata);
      if (out_tvalid && out_tready) begin
        if (plot_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d data=%h last=%0d", $time,
                   out_tuser[0], out_tdata, out_tlast);
          failed = 1'b1;
        end else begin
          e = plot_q.pop_front();
          if (out_tuser[0] !== e.kind || out_tdata[3:0] !== e.sector ||
              out_tdata[19:4] !== e.az || out_tdata[35:20] !== e.rng ||
              out_tdata[43:36] !== e.height || out_tdata[47:44] !== 4'd0 ||
              out_tlast !== e.last) begin
            $display("%0t: mismatch expected kind=%0d sec=%h az=%h rng=%h h=%h last=%0d",
                     $time, e.kind, e.sector, e.az, e.rng, e.height, e.last);
            $display("%0t:          actual   kind=%0d sec=%h az=%h rng=%h h=%h last=%0d",
                     $time, out_tuser[0], out_tdata[3:0], out_tdata[19:4],
                     out_tdata[35:20], out_tdata[43:36], out_tlast);
            failed = 1'b1;
          end
        end
      end
    end
    // watchdog on transactions of any kind
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [12:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = val;
    case (addr)
      CfgRangeTol: m_tol = val[11:0];
      CfgMaxAbs:   m_max_abs = val[7:0];
      CfgTurnCnt:  m_turn = val;
      CfgMinWidth: m_min_w = val[11:0];
      CfgInhibit:  m_inhibit = val[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(int tol, int mabs, int turn, int minw, int inh);
    write_reg(CfgRangeTol, 13'(tol));
    write_reg(CfgMaxAbs, 13'(mabs));
    write_reg(CfgTurnCnt, 13'(turn));
    write_reg(CfgMinWidth, 13'(minw));
    write_reg(CfgInhibit, 13'(inh));
  endtask

  // wait until the sender and the expected results have drained, then let the tail of its work settle
  task automatic drain();
    while (word_q.size() != 0 || in_tvalid || plot_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Antenna sweep: azimuth steps of 1 to 3 with echoes around four target ranges, plus stray words
  task automatic push_sweep(int steps);
    logic [15:0] az;
    logic [11:0] base [4];
    int n;
    az = {4'h8, 12'($urandom)};
    foreach (base[k]) base[k] = 12'($urandom_range(0, 4095));
    word_q.push_back(az);
    for (int s = 0; s < steps; s++) begin
      case ($urandom_range(0, 19))
        0: word_q.push_back(16'($urandom));
        1: word_q.push_back({4'h8, 12'($urandom)});
        2: word_q.push_back(az);
        default: ;
      endcase
      az = {4'h8, 12'(az[11:0] + $urandom_range(1, 3))};
      word_q.push_back(az);
      n = $urandom_range(0, 3);
      for (int r = 0; r < n; r++) begin
        if ($urandom_range(0, 9) == 0) word_q.push_back({4'hC, 12'($urandom)});
        word_q.push_back({4'h3, 12'(base[$urandom_range(0, 3)] + $urandom_range(0, 6))});
      end
    end
  endtask

  initial begin
    m_tol = 12'd8; m_max_abs = 8'd4; m_turn = 13'd4096; m_min_w = 12'd2; m_inhibit = 12'd13;
    m_last_az = '0; m_resync = 1'b1; m_az_valid = 1'b0; m_run_closed = 1'b0;
    m_sector = '0; m_run_rng = '0; m_run_az = '0; m_h_pending = 1'b0;
    m_pend_h = '0; m_count = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: first azimuth closes the empty run, heights, inhibit, rejects
    word_q = '{16'h8000, 16'h3000, 16'h300C, 16'h3100, 16'h3104, 16'h3110, 16'hC0FF,
               16'h3112, 16'h8001, 16'h0000, 16'hFFFF, 16'h3FFF, 16'h3100, 16'h8001,
               16'h8005, 16'h8100, 16'h3105, 16'h8101, 16'h8102, 16'h8FFF, 16'h8000,
               16'h8002, 16'h8003, 16'h8004, 16'h8005};
    drain();

    // zero tolerance: fill the table past its depth, long lifetime
    set_regs(0, 255, 4096, 0, 0);
    word_q.push_back(16'h8200);
    for (int i = 0; i < 40; i++) word_q.push_back(16'(16'h3000 + i * 16));
    word_q.push_back(16'h8201);
    drain();
    // flush everything at once with a short lifetime
    set_regs(0, 1, 4096, 0, 0);
    word_q = '{16'h8202};
    drain();

    // opposite extremes
    set_regs(4095, 1, 0, 4095, 4095);
    word_q = '{16'h8FFD, 16'h3FFF, 16'h3FFF, 16'h8FFE, 16'h3FFF, 16'h8FFF, 16'h8000};
    push_sweep(8);
    drain();

    // wrap midpoint with a short turn and wide lifetime
    set_regs(20, 3, 2048, 1, 100);
    push_sweep(28);
    drain();

    hold_input = 1'b1;
    set_regs($urandom_range(4, 40), $urandom_range(2, 8), $urandom_range(0, 4096),
             $urandom_range(0, 6), $urandom_range(0, 200));
    push_sweep(28);
    repeat (50) @(posedge clk);
    hold_input = 1'b0;
    drain();

    set_regs(8, 4, 4096, 2, 13);
    push_sweep(22);
    drain();

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
